@@ rtl/core/ppb_pkg.sv @@
// ----------------------------------------------------------------------------
// ppb_pkg
// Shared widths, constants and arithmetic helpers for the palette pulse blend.
// ----------------------------------------------------------------------------
package ppb_pkg;

   localparam int COLOR_W = 15;
   localparam int CHAN_W  = 5;
   localparam int PHASE_W = 5;
   localparam int WEIGHT_W = 4;

   typedef logic [COLOR_W-1:0]  color_type;
   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [PHASE_W-1:0]  phase_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   localparam logic [6:0]  TINT_BIAS  = 7'h5D;
   localparam weight_type  K_MAX      = 4'hF;
   localparam phase_type   PHASE_FOLD = 5'h1E;
   localparam phase_type   PHASE_LAST = 5'h1D;
   localparam logic [8:0]  BLEND_DIV  = 9'd15;
   // 17/256 sits just under 1/15; one correction step fixes the quotient
   localparam logic [13:0] RECIP_MUL  = 14'd17;

   // Fold the phase into a triangle weight 0..15.
   function automatic weight_type fold_weight(phase_type phase);
      phase_type diff;
      diff = PHASE_FOLD - phase;
      if (phase <= {1'b0, K_MAX}) begin
         return phase[WEIGHT_W-1:0];
      end else if (phase >= PHASE_FOLD) begin
         return '0;
      end else begin
         return diff[WEIGHT_W-1:0];
      end
   endfunction

   // Blend one 5-bit channel toward its tint by weight k, divided by 15.
   function automatic chan_type blend_channel(chan_type c, weight_type k);
      logic [6:0]  tint_sum;
      chan_type    tint;
      weight_type  kinv;
      logic [8:0]  sum;
      logic [13:0] prod;
      chan_type    q0;
      logic [8:0]  rem;
      tint_sum = {2'd0, c} + TINT_BIAS;
      tint     = tint_sum[6:2];
      kinv     = K_MAX - k;
      sum      = 9'({4'd0, c} * {5'd0, kinv}) + 9'({4'd0, tint} * {5'd0, k});
      prod     = {5'd0, sum} * RECIP_MUL;
      q0       = prod[12:8];
      rem      = sum - 9'({4'd0, q0} * BLEND_DIV);
      if (rem >= BLEND_DIV) begin
         return q0 + 5'd1;
      end else begin
         return q0;
      end
   endfunction

endpackage

@@ rtl/core/ppb_req_if.sv @@
// ----------------------------------------------------------------------------
// ppb_req_if
// Input word channel: one palette color with its end-of-batch mark.
// ----------------------------------------------------------------------------
interface ppb_req_if;
   logic                valid;
   logic                ready;
   ppb_pkg::color_type  color_in;
   logic                batch_end;

   modport source (output valid, output color_in, output batch_end, input ready);
   modport sink   (input valid, input color_in, input batch_end, output ready);
endinterface

@@ rtl/core/ppb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ppb_rsp_if
// Result word channel: one blended color with its end-of-batch mark.
// ----------------------------------------------------------------------------
interface ppb_rsp_if;
   logic                valid;
   logic                ready;
   ppb_pkg::color_type  color_out;
   logic                batch_done;

   modport source (output valid, output color_out, output batch_done, input ready);
   modport sink   (input valid, input color_out, input batch_done, output ready);
endinterface

@@ rtl/core/ppb_phase.sv @@
// ----------------------------------------------------------------------------
// ppb_phase
// Pulse phase counter 0..29 and its folded triangle weight.
// ----------------------------------------------------------------------------
module ppb_phase (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   output ppb_pkg::weight_type  weight
);
   import ppb_pkg::*;

   phase_type phase_ff;
   phase_type phase_in;

   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         // wrap after the last phase
         if (phase_ff >= PHASE_LAST) begin
            phase_in = '0;
         end else begin
            phase_in = phase_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign weight = fold_weight(phase_ff);

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("pulse phase out of range");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff != PHASE_LAST |=> phase_ff == $past(phase_ff) + 5'd1)
      else $error("pulse phase did not advance");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff))
      else $error("pulse phase moved without a batch end");

endmodule

@@ rtl/core/ppb_blend.sv @@
// ----------------------------------------------------------------------------
// ppb_blend
// Blend all three RGB555 channels of one color by a shared weight.
// ----------------------------------------------------------------------------
module ppb_blend (
   input  ppb_pkg::color_type   color,
   input  ppb_pkg::weight_type  weight,
   output ppb_pkg::color_type   blended
);
   import ppb_pkg::*;

   chan_type red;
   chan_type green;
   chan_type blue;

   assign red     = blend_channel(color[4:0], weight);
   assign green   = blend_channel(color[9:5], weight);
   assign blue    = blend_channel(color[14:10], weight);
   assign blended = {blue, green, red};

endmodule

@@ rtl/core/palette_pulse_blend.sv @@
// ----------------------------------------------------------------------------
// palette_pulse_blend
// Pulse a stream of RGB555 palette colors toward a brightened tint.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                 | notes
//  ---------+-----+------------------------+-------------------------------
//  req_ch   | in  | color_in, batch_end    | one color word per handshake
//  rsp_ch   | out | color_out, batch_done  | one blended word per request
//
//  Throughput is one word per cycle while rsp_ch.ready holds; a word taken
//  passes the input register, then the result register, before it is valid.
//  The weight is captured from the phase counter when a word is taken, so all
//  words of a batch see the same phase; the phase steps on taking batch_end.
//  Reset (synchronous) empties both stages and clears the phase to zero.
//  A stalled result holds in the result register while the input register
//  still takes one more word; ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module palette_pulse_blend (
   input logic   clock,
   input logic   reset,
   ppb_req_if.sink   req_ch,
   ppb_rsp_if.source rsp_ch
);
   import ppb_pkg::*;

   // input stage
   logic       s1_valid_ff;
   logic       s1_valid_in;
   color_type  s1_color_ff;
   logic       s1_end_ff;
   weight_type s1_weight_ff;

   // result stage
   logic       s2_valid_ff;
   logic       s2_valid_in;
   color_type  s2_color_ff;
   logic       s2_end_ff;

   logic       req_take;
   logic       s1_adv;
   logic       s2_adv;
   weight_type cur_weight;
   color_type  blended;

   // advance the result stage when empty or when the sink takes the word
   assign s2_adv   = !s2_valid_ff || rsp_ch.ready;
   // advance the input stage when empty or when it can move down
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign req_take = req_ch.valid && s1_adv;

   assign req_ch.ready = s1_adv;

   // phase counter steps after the last color of a batch is taken
   ppb_phase u_phase (
      .clock  (clock),
      .reset  (reset),
      .step   (req_take && req_ch.batch_end),
      .weight (cur_weight)
   );

   ppb_blend u_blend (
      .color   (s1_color_ff),
      .weight  (s1_weight_ff),
      .blended (blended)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s1_valid_in = req_ch.valid;
      end
      if (s2_adv) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload: load input word with the weight of the current phase
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_color_ff  <= req_ch.color_in;
         s1_end_ff    <= req_ch.batch_end;
         s1_weight_ff <= cur_weight;
      end
   end

   // payload: hold result until taken, then load the next blended word
   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         s2_color_ff <= blended;
         s2_end_ff   <= s1_end_ff;
      end
   end

   assign rsp_ch.valid      = s2_valid_ff;
   assign rsp_ch.color_out  = s2_color_ff;
   assign rsp_ch.batch_done = s2_end_ff;

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && s2_valid_ff)
      else $error("request stalled with a free stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline not empty after reset");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_adv |=> s1_valid_ff && $stable(s1_color_ff))
      else $error("input stage lost a word under stall");

   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_adv |=> s2_valid_ff && s2_end_ff == $past(s1_end_ff))
      else $error("word not moved into result stage");

endmodule

@@ dv/tb_palette_pulse_blend.sv @@
// ----------------------------------------------------------------------------
// tb_palette_pulse_blend
// Self-checking bench for the palette pulse blend. Streams batches of RGB555
// colors through the request channel, predicts every blended word from its
// own copy of the phase counter, and compares each result word in order.
// ----------------------------------------------------------------------------
module tb_palette_pulse_blend;
   import ppb_pkg::*;

   localparam int RAND_WORDS   = 1900;  // random words after the directed part
   localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
   localparam int DRAIN_CYCLES = 8;     // two-stage pipe, plus margin
   localparam int MODE_CYCLES  = 300;   // length of one receiver stall mode

   // one blended word as it should appear on the result channel
   typedef struct packed {
      color_type color;
      logic      done;
   } blend_word_type;

   // -------------------------------------------------------------------------
   // Predictor and in-order checker for blended words.
   // -------------------------------------------------------------------------
   class blend_scoreboard;
      phase_type      phase;
      blend_word_type pending[$];
      int             errors;

      function new();
         phase  = '0;
         errors = 0;
      endfunction

      // triangle weight from the current phase
      function int pulse_weight();
         int p;
         p = int'(phase);
         if (p <= int'(K_MAX)) begin
            return p;
         end
         if (p >= int'(PHASE_FOLD)) begin
            return 0;
         end
         return int'(PHASE_FOLD) - p;
      endfunction

      function chan_type mix_channel(int c, int k);
         int tint;
         int total;
         tint  = (c + int'(TINT_BIAS)) >> 2;
         total = c * (int'(K_MAX) - k) + k * tint;
         return chan_type'((total / int'(BLEND_DIV)) & 'h1F);
      endfunction

      // Predict the word for an accepted color; step the phase on batch end.
      function void note_word(color_type c, logic e);
         blend_word_type w;
         int             k;
         int             nxt;
         k = pulse_weight();
         w.color = {mix_channel(int'(c[14:10]), k),
                    mix_channel(int'(c[9:5]), k),
                    mix_channel(int'(c[4:0]), k)};
         w.done  = e;
         pending.push_back(w);
         if (e) begin
            nxt = int'(phase) + 1;
            if (nxt > int'(PHASE_LAST)) begin
               nxt = 0;
            end
            phase = phase_type'(nxt);
         end
      endfunction

      function void check_word(color_type c, logic d);
         blend_word_type w;
         if (pending.size() == 0) begin
            $error("unexpected result word: color_out=%h batch_done=%b", c, d);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (c !== w.color) begin
            $error("color_out mismatch: expected %h, actual %h", w.color, c);
            errors++;
         end
         if (d !== w.done) begin
            $error("batch_done mismatch: expected %b, actual %b", w.done, d);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ppb_req_if req_if ();
   ppb_rsp_if rsp_if ();

   palette_pulse_blend u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   blend_scoreboard sb = new();

   int burst_left = 0;   // words left in the current sender burst
   bit steady     = 0;   // when set, the sender streams with no gaps
   int cycle_cnt  = 0;
   int quiet_cnt  = 0;   // cycles since the last handshake on either side

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Receiver: rotate through stall modes so stalls land on every pipe phase.
   // Mode 0 never stalls, mode 1 takes one word in three, mode 2 is a coin
   // flip, mode 3 stalls rarely.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      case ((cycle_cnt / MODE_CYCLES) % 4)
         0: begin
            rsp_if.ready <= 1'b1;
         end
         1: begin
            rsp_if.ready <= (cycle_cnt % 3) == 0;
         end
         2: begin
            rsp_if.ready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_if.ready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Monitor: note accepted colors, check accepted results, and watch for a
   // hang. Values are sampled before this edge's updates land.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_word(req_if.color_in, req_if.batch_end);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_word(rsp_if.color_out, rsp_if.batch_done);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cnt <= 0;
         end else if (quiet_cnt >= STALL_LIMIT) begin
            $display("tb_palette_pulse_blend: done, errors");
            $finish;
         end else begin
            quiet_cnt <= quiet_cnt + 1;
         end
      end
   end

   // Drop valid, then wait out the idle gap given by n.
   task automatic idle(int n);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Send one color word; pace the sender in bursts with random gaps.
   task automatic send_color(color_type c, logic e);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            idle(gap);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.color_in  <= c;
      req_if.batch_end <= e;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Hold the sender until every predicted word has come back.
   task automatic drain_pause();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() > 0) @(posedge clock);
   endtask

   function automatic chan_type pick_channel();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return chan_type'($urandom_range(0, 31));
      endcase
   endfunction

   // Mostly uniform colors, with some built from channel extremes.
   function automatic color_type pick_color();
      if ($urandom_range(0, 4) == 0) begin
         return {pick_channel(), pick_channel(), pick_channel()};
      end
      return color_type'($urandom_range(0, 32767));
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int sent;
      int blen;
      int pause_at;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.color_in  <= '0;
      req_if.batch_end <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and single channels at phases zero to two, with
      // multi-word batches so several colors share one phase.
      steady = 1;
      send_color(15'h0000, 1'b0);
      send_color(15'h7FFF, 1'b0);
      send_color(15'h001F, 1'b1);
      send_color(15'h03E0, 1'b0);
      send_color(15'h7C00, 1'b1);
      send_color(15'h5555, 1'b0);
      send_color(15'h2AAA, 1'b1);
      // Walk the phase through the top of the triangle with one-word batches
      // so the full weight and the falling side both show up.
      for (int i = 0; i < 18; i++) begin
         send_color((i % 2) ? 15'h7FFF : 15'h0000, 1'b1);
      end
      steady = 0;
      drain_pause();

      // Random batches; the phase wraps many times over the run.
      sent     = 0;
      pause_at = RAND_WORDS / 2;
      while (sent < RAND_WORDS) begin
         case ($urandom_range(0, 19))
            0:       blen = $urandom_range(7, 24);
            1, 2:    blen = 1;
            default: blen = $urandom_range(1, 6);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            steady = !steady;
         end
         for (int i = 0; i < blen; i++) begin
            send_color(pick_color(), i == blen - 1);
         end
         sent += blen;
         if (pause_at > 0 && sent >= pause_at) begin
            pause_at = 0;
            drain_pause();
         end
      end
      req_if.valid <= 1'b0;

      // Wait out the pipe; the watchdog bounds this loop.
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb_palette_pulse_blend: done, clean");
      end else begin
         $display("tb_palette_pulse_blend: done, errors");
      end
      $finish;
   end

endmodule
